// ----- rtl/text_cursor_controller_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef TEXT_CURSOR_CONTROLLER_TOP_MACROS_SVH
`define TEXT_CURSOR_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define TCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text cursor controller check failed");

// Next-cycle implication, disabled while reset is high
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text cursor controller check failed");

`endif

// ----- rtl/tcc_pkg.sv -----
package tcc_pkg;

   // Default cursor coordinate width; the cursor holds one bit more
   localparam int COORD_BITS_DEF = 12;

   // Field widths
   localparam int POS_W      = 13;
   localparam int CHAR_W     = 8;
   localparam int SET_W      = 12;
   localparam int WIN_POS_W  = 12;
   localparam int WIN_SIZE_W = 13;
   localparam int CELL_W     = 7;
   localparam int TAB_W      = 12;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   // Mode flag bits
   localparam int MODE_WRAP   = 0;
   localparam int MODE_SCROLL = 1;
   localparam int MODE_OPAQUE = 2;

   // Control characters
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

   // Operation codes
   localparam logic OP_PRINT = 1'b0;
   localparam logic OP_SET   = 1'b1;

   // Register reset values
   localparam logic [WIN_POS_W-1:0]  RST_WIN_X = 12'd0;
   localparam logic [WIN_POS_W-1:0]  RST_WIN_Y = 12'd0;
   localparam logic [WIN_SIZE_W-1:0] RST_WIN_W = 13'd640;
   localparam logic [WIN_SIZE_W-1:0] RST_WIN_H = 13'd480;
   localparam logic [CELL_W-1:0]     RST_CELL_W = 7'd8;
   localparam logic [CELL_W-1:0]     RST_CELL_H = 7'd16;
   localparam logic [TAB_W-1:0]      RST_TAB   = 12'd64;
   localparam logic [MODE_W-1:0]     RST_MODE  = 3'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIN_X  = 4'd0,
      CSR_WIN_Y  = 4'd1,
      CSR_WIN_W  = 4'd2,
      CSR_WIN_H  = 4'd3,
      CSR_CELL_W = 4'd4,
      CSR_CELL_H = 4'd5,
      CSR_TAB    = 4'd6,
      CSR_MODE   = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_GLYPH  = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_SCROLL = 2'd2
   } rsp_cmd_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_SET,
      CUR_ADV,
      CUR_TAB,
      CUR_NL,
      CUR_HOME
   } cur_op_type;

   typedef enum logic [1:0] {
      DIV_TAB,
      DIV_WIDTH,
      DIV_HEIGHT
   } div_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        latch;
      logic        div_start;
      div_sel_type div_sel;
      logic        emit;
      rsp_cmd_type emit_cmd;
      logic        emit_last;
      cur_op_type  cur_op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_set;
      logic is_tab;
      logic is_newline;
      logic opaque;
      logic wrap_glyph;
      logic wrap_tab;
      logic scroll_hit;
      logic div_done;
      logic slot_free;
   } dp_status_type;

endpackage

// ----- rtl/tcc_div.sv -----
module tcc_div
   import tcc_pkg::*;
#(
   parameter int DW = 13,
   parameter int VW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [VW-1:0] rem,
   output logic          done
);

   localparam int CNT_W = $clog2(DW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [VW-1:0]    dsr_ff, dsr_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW:0]      trial;
   logic [VW:0]      diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[VW-1:0] : trial[VW-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// ----- rtl/tcc_dpath.sv -----
module tcc_dpath
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  req_operation,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [SET_W-1:0]      req_set_col,
   input  logic [SET_W-1:0]      req_set_row,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_command,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   output logic [CHAR_W-1:0]     rsp_glyph,
   output logic [POS_W-1:0]      rsp_box_w,
   output logic [POS_W-1:0]      rsp_box_h,
   output logic                  rsp_last
);

   localparam int CW = COORD_BITS + 1;
   localparam int DW = (CW > WIN_SIZE_W) ? CW : WIN_SIZE_W;
   localparam int TW = DW + 1;
   localparam int SW = DW + 2;

   // Configuration registers
   logic [WIN_POS_W-1:0]  win_x_ff, win_y_ff;
   logic [WIN_SIZE_W-1:0] win_w_ff, win_h_ff;
   logic [CELL_W-1:0]     cell_w_ff, cell_h_ff;
   logic [TAB_W-1:0]      tab_ff;
   logic [MODE_W-1:0]     mode_ff;

   // Latched request
   logic              op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [SET_W-1:0]  set_col_ff, set_row_ff;

   // Cursor and intermediate results
   logic [CW-1:0]         col_ff, col_in, row_ff, row_in;
   logic [TW-1:0]         tab_col_ff;
   logic [WIN_SIZE_W-1:0] span_w_ff, span_h_ff;
   div_sel_type           div_sel_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        command_ff, command_in;
   logic [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [CHAR_W-1:0] glyph_ff, glyph_in;
   logic [POS_W-1:0]  box_w_ff, box_w_in, box_h_ff, box_h_in;
   logic              last_ff, last_in;

   // Divider interface
   logic [DW-1:0]    div_dividend;
   logic [TAB_W-1:0] div_divisor;
   logic [TAB_W-1:0] div_rem;
   logic             div_done;

   // Wide sums for the edge tests
   logic [SW-1:0] col_sw, row_sw, tab_sw, cw_sw, ch_sw, col_adv, row_adv;
   logic [POS_W-1:0] col13, row13, abs_x, abs_y;
   logic is_ctrl;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff  <= RST_WIN_X;
         win_y_ff  <= RST_WIN_Y;
         win_w_ff  <= RST_WIN_W;
         win_h_ff  <= RST_WIN_H;
         cell_w_ff <= RST_CELL_W;
         cell_h_ff <= RST_CELL_H;
         tab_ff    <= RST_TAB;
         mode_ff   <= RST_MODE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIN_X:  win_x_ff  <= csr_wdata[WIN_POS_W-1:0];
            CSR_WIN_Y:  win_y_ff  <= csr_wdata[WIN_POS_W-1:0];
            CSR_WIN_W:  win_w_ff  <= csr_wdata[WIN_SIZE_W-1:0];
            CSR_WIN_H:  win_h_ff  <= csr_wdata[WIN_SIZE_W-1:0];
            CSR_CELL_W: cell_w_ff <= csr_wdata[CELL_W-1:0];
            CSR_CELL_H: cell_h_ff <= csr_wdata[CELL_W-1:0];
            CSR_TAB:    tab_ff    <= csr_wdata[TAB_W-1:0];
            CSR_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold the accepted request beat
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_operation;
         char_ff    <= req_char_code;
         set_col_ff <= req_set_col;
         set_row_ff <= req_set_row;
      end
   end

   assign col_sw  = SW'(col_ff);
   assign row_sw  = SW'(row_ff);
   assign tab_sw  = SW'(tab_col_ff);
   assign cw_sw   = SW'(cell_w_ff);
   assign ch_sw   = SW'(cell_h_ff);
   assign col_adv = col_sw + cw_sw;
   assign row_adv = row_sw + ch_sw;

   // Decode and edge tests for the controller
   assign is_ctrl = (tab_ff != '0) && (char_ff inside {CHAR_TAB, CHAR_LF, CHAR_CR});

   always_comb begin
      status            = '0;
      status.op_set     = (op_ff == OP_SET);
      status.is_tab     = is_ctrl && (char_ff == CHAR_TAB);
      status.is_newline = is_ctrl && (char_ff != CHAR_TAB);
      status.opaque     = mode_ff[MODE_OPAQUE];
      status.wrap_glyph = mode_ff[MODE_WRAP] && (col_adv + cw_sw > SW'(win_w_ff));
      status.wrap_tab   = mode_ff[MODE_WRAP] && (tab_sw + cw_sw > SW'(win_w_ff));
      status.scroll_hit = mode_ff[MODE_SCROLL] && (row_adv + ch_sw > SW'(win_h_ff));
      status.div_done   = div_done;
      status.slot_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Select divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_TAB: begin
            div_dividend = DW'(col_ff);
            div_divisor  = tab_ff;
         end
         DIV_WIDTH: begin
            div_dividend = DW'(win_w_ff);
            div_divisor  = TAB_W'(cell_w_ff);
         end
         DIV_HEIGHT: begin
            div_dividend = DW'(win_h_ff);
            div_divisor  = TAB_W'(cell_h_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   tcc_div #(
      .DW (DW),
      .VW (TAB_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .rem      (div_rem),
      .done     (div_done)
   );

   // Round down from the remainder: next tab stop, scroll span
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         case (div_sel_ff)
            DIV_TAB:
               tab_col_ff <= TW'(col_ff) - TW'(div_rem) + TW'(tab_ff);
            DIV_WIDTH:
               span_w_ff <= (cell_w_ff == '0) ? '0 : win_w_ff - WIN_SIZE_W'(div_rem);
            DIV_HEIGHT:
               span_h_ff <= (cell_h_ff == '0) ? '0 : win_h_ff - WIN_SIZE_W'(div_rem);
            default: ;
         endcase
      end
   end

   // Advance the cursor
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.cur_op)
         CUR_HOLD: ;
         CUR_SET: begin
            col_in = CW'(set_col_ff);
            row_in = CW'(set_row_ff);
         end
         CUR_ADV:  col_in = col_adv[CW-1:0];
         CUR_TAB:  col_in = tab_col_ff[CW-1:0];
         CUR_NL: begin
            col_in = '0;
            row_in = row_adv[CW-1:0];
         end
         CUR_HOME: col_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Build the result beat
   assign col13 = POS_W'(col_ff);
   assign row13 = POS_W'(row_ff);
   assign abs_x = POS_W'(win_x_ff) + col13;
   assign abs_y = POS_W'(win_y_ff) + row13;

   always_comb begin
      command_in   = command_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      glyph_in     = glyph_ff;
      box_w_in     = box_w_ff;
      box_h_in     = box_h_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         command_in   = cmd.emit_cmd;
         last_in      = cmd.emit_last;
         case (cmd.emit_cmd)
            CMD_GLYPH: begin
               pos_x_in = abs_x;
               pos_y_in = abs_y;
               glyph_in = char_ff;
               box_w_in = '0;
               box_h_in = '0;
            end
            CMD_FILL: begin
               pos_x_in = abs_x;
               pos_y_in = abs_y;
               glyph_in = '0;
               box_w_in = tab_col_ff[POS_W-1:0] - col13;
               box_h_in = POS_W'(cell_h_ff);
            end
            CMD_SCROLL: begin
               pos_x_in = POS_W'(win_x_ff);
               pos_y_in = POS_W'(win_y_ff);
               glyph_in = '0;
               box_w_in = span_w_ff;
               box_h_in = span_h_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      command_ff <= command_in;
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      glyph_ff   <= glyph_in;
      box_w_ff   <= box_w_in;
      box_h_ff   <= box_h_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = command_ff;
   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_glyph   = glyph_ff;
   assign rsp_box_w   = box_w_ff;
   assign rsp_box_h   = box_h_ff;
   assign rsp_last    = last_ff;

endmodule

// ----- rtl/tcc_ctrl.sv -----
module tcc_ctrl
   import tcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GLYPH,
      ST_TAB_WAIT,
      ST_TAB_DONE,
      ST_LINE,
      ST_WIDTH_WAIT,
      ST_HEIGHT_WAIT,
      ST_SCROLL
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Sequence one item through decode, divide and emit
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op_set) begin
               cmd.cur_op = CUR_SET;
               state_in   = ST_IDLE;
            end else if (status.is_tab) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_TAB;
               state_in      = ST_TAB_WAIT;
            end else if (status.is_newline) begin
               state_in = ST_LINE;
            end else begin
               state_in = ST_GLYPH;
            end
         end
         ST_GLYPH: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_cmd  = CMD_GLYPH;
               cmd.emit_last = !(status.wrap_glyph && status.scroll_hit);
               cmd.cur_op    = CUR_ADV;
               state_in      = status.wrap_glyph ? ST_LINE : ST_IDLE;
            end
         end
         ST_TAB_WAIT: begin
            if (status.div_done) begin
               state_in = ST_TAB_DONE;
            end
         end
         ST_TAB_DONE: begin
            if (!status.opaque) begin
               cmd.cur_op = CUR_TAB;
               state_in   = status.wrap_tab ? ST_LINE : ST_IDLE;
            end else if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_cmd  = CMD_FILL;
               cmd.emit_last = !(status.wrap_tab && status.scroll_hit);
               cmd.cur_op    = CUR_TAB;
               state_in      = status.wrap_tab ? ST_LINE : ST_IDLE;
            end
         end
         ST_LINE: begin
            if (!status.scroll_hit) begin
               cmd.cur_op = CUR_NL;
               state_in   = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_WIDTH;
               state_in      = ST_WIDTH_WAIT;
            end
         end
         ST_WIDTH_WAIT: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_HEIGHT;
               state_in      = ST_HEIGHT_WAIT;
            end
         end
         ST_HEIGHT_WAIT: begin
            if (status.div_done) begin
               state_in = ST_SCROLL;
            end
         end
         ST_SCROLL: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_cmd  = CMD_SCROLL;
               cmd.emit_last = 1'b1;
               cmd.cur_op    = CUR_HOME;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/text_cursor_controller_top.sv -----
// Set cursor passes through decode only; a plain glyph passes decode and an emit state.
// A tab waits on one pass of the shared restoring divider, then moves or fills.
// A new line that scrolls adds two divider passes and the scroll beat.
// One item is in work at a time; results leave through a one-beat output register.
// Reset is synchronous: registers return to defaults, cursor to origin, output empty.
module text_cursor_controller_top
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [SET_W-1:0]      req_set_col,
   input  logic [SET_W-1:0]      req_set_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_command,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   output logic [CHAR_W-1:0]     rsp_glyph,
   output logic [POS_W-1:0]      rsp_box_w,
   output logic [POS_W-1:0]      rsp_box_h,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes complete at once
   assign csr_ready = 1'b1;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcc_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .req_set_col   (req_set_col),
      .req_set_row   (req_set_row),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_command   (rsp_command),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_glyph     (rsp_glyph),
      .rsp_box_w     (rsp_box_w),
      .rsp_box_h     (rsp_box_h),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/tcc_checker.sv -----
`include "text_cursor_controller_top_macros.svh"

module tcc_checker
   import tcc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_command,
   input logic [POS_W-1:0] rsp_pos_x,
   input logic [POS_W-1:0] rsp_box_w,
   input logic [POS_W-1:0] rsp_box_h,
   input logic             rsp_last
);

   // A stalled result beat stays put
   `TCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_command) && $stable(rsp_pos_x) && $stable(rsp_last))

   // A glyph draw carries no box
   `TCC_ASSERT_IMPL(a_glyph_no_box, clock, reset, rsp_valid && rsp_command == CMD_GLYPH, rsp_box_w == '0 && rsp_box_h == '0)

   // A scroll always closes its item
   `TCC_ASSERT_IMPL(a_scroll_last, clock, reset, rsp_valid && rsp_command == CMD_SCROLL, rsp_last)

   // An accepted item blocks the next one
   `TCC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind text_cursor_controller_top tcc_checker u_checker (.*);

// ----- test/text_cursor_checker.sv -----
`timescale 1ns / 100ps

module text_cursor_checker
   import tcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_operation,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [SET_W-1:0]      req_set_col,
   input  logic [SET_W-1:0]      req_set_row,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_command,
   input  logic [POS_W-1:0]      rsp_pos_x,
   input  logic [POS_W-1:0]      rsp_pos_y,
   input  logic [CHAR_W-1:0]     rsp_glyph,
   input  logic [POS_W-1:0]      rsp_box_w,
   input  logic [POS_W-1:0]      rsp_box_h,
   input  logic                  rsp_last,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fault_count,
   output int                    outstanding
);

   localparam int CUR_W = COORD_BITS_DEF + 1;

   typedef struct {
      rsp_cmd_type       command;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [CHAR_W-1:0] glyph;
      logic [POS_W-1:0]  box_w;
      logic [POS_W-1:0]  box_h;
      logic              last;
   } draw_cmd_type;

   // Mirror of the register file
   logic [WIN_POS_W-1:0]  win_x;
   logic [WIN_POS_W-1:0]  win_y;
   logic [WIN_SIZE_W-1:0] win_w;
   logic [WIN_SIZE_W-1:0] win_h;
   logic [CELL_W-1:0]     cell_w;
   logic [CELL_W-1:0]     cell_h;
   logic [TAB_W-1:0]      tab_step;
   logic [MODE_W-1:0]     mode;

   // Cursor, window-relative
   logic [CUR_W-1:0] cur_col;
   logic [CUR_W-1:0] cur_row;

   // Commands still owed by the block, oldest first
   draw_cmd_type draw_expect[$];
   // Commands of the item being planned
   draw_cmd_type staged[$];

   function automatic void stage_cmd(rsp_cmd_type cmd, int unsigned x, int unsigned y,
                                     int unsigned g, int unsigned bw, int unsigned bh);
      draw_cmd_type c;
      c.command = cmd;
      c.pos_x   = x[POS_W-1:0];
      c.pos_y   = y[POS_W-1:0];
      c.glyph   = g[CHAR_W-1:0];
      c.box_w   = bw[POS_W-1:0];
      c.box_h   = bh[POS_W-1:0];
      c.last    = 1'b0;
      staged.push_back(c);
   endfunction

   // Return to line start; scroll when the next line would cross the bottom edge
   task automatic feed_line(inout int unsigned col, inout int unsigned row);
      int unsigned span_w;
      int unsigned span_h;
      col = 0;
      row += cell_h;
      if (mode[MODE_SCROLL] && row + cell_h > win_h) begin
         span_w = (cell_w != 0) ? (win_w / cell_w) * cell_w : 0;
         span_h = (cell_h != 0) ? (win_h / cell_h) * cell_h : 0;
         stage_cmd(CMD_SCROLL, win_x, win_y, 0, span_w, span_h);
         row -= cell_h;
      end
   endtask

   // Work out the commands of one accepted item and move the cursor
   task automatic plan_commands(logic op, logic [CHAR_W-1:0] ch,
                                logic [SET_W-1:0] scol, logic [SET_W-1:0] srow);
      int unsigned col;
      int unsigned row;
      int unsigned ox;
      col = cur_col;
      row = cur_row;
      staged.delete();
      if (op == OP_SET) begin
         cur_col = CUR_W'(scol);
         cur_row = CUR_W'(srow);
         return;
      end
      if (tab_step != 0 && (ch == CHAR_TAB || ch == CHAR_LF || ch == CHAR_CR)) begin
         if (ch == CHAR_TAB) begin
            ox = col;
            col = (col / tab_step + 1) * tab_step;
            if (mode[MODE_OPAQUE])
               stage_cmd(CMD_FILL, win_x + ox, win_y + row, 0, col - ox, cell_h);
            if (mode[MODE_WRAP] && col + cell_w > win_w)
               feed_line(col, row);
         end else begin
            feed_line(col, row);
         end
      end else begin
         stage_cmd(CMD_GLYPH, win_x + col, win_y + row, ch, 0, 0);
         col += cell_w;
         if (mode[MODE_WRAP] && col + cell_w > win_w)
            feed_line(col, row);
      end
      if (staged.size() > 0)
         staged[staged.size() - 1].last = 1'b1;
      foreach (staged[k])
         draw_expect.push_back(staged[k]);
      cur_col = col[CUR_W-1:0];
      cur_row = row[CUR_W-1:0];
   endtask

   function automatic void load_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_WIN_X:  win_x    = d[WIN_POS_W-1:0];
         CSR_WIN_Y:  win_y    = d[WIN_POS_W-1:0];
         CSR_WIN_W:  win_w    = d[WIN_SIZE_W-1:0];
         CSR_WIN_H:  win_h    = d[WIN_SIZE_W-1:0];
         CSR_CELL_W: cell_w   = d[CELL_W-1:0];
         CSR_CELL_H: cell_h   = d[CELL_W-1:0];
         CSR_TAB:    tab_step = d[TAB_W-1:0];
         CSR_MODE:   mode     = d[MODE_W-1:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      draw_cmd_type want;
      if (reset) begin
         win_x = RST_WIN_X;
         win_y = RST_WIN_Y;
         win_w = RST_WIN_W;
         win_h = RST_WIN_H;
         cell_w = RST_CELL_W;
         cell_h = RST_CELL_H;
         tab_step = RST_TAB;
         mode = RST_MODE;
         cur_col = '0;
         cur_row = '0;
         draw_expect.delete();
         fault_count = 0;
      end else begin
         // Check the result beat against the oldest owed command
         if (rsp_valid && !rsp_stall) begin
            if (draw_expect.size() == 0) begin
               if (fault_count < 10)
                  $display("%0t: result beat with nothing owed: cmd %0d x %0d y %0d",
                           $time, rsp_command, rsp_pos_x, rsp_pos_y);
               fault_count++;
            end else begin
               want = draw_expect.pop_front();
               if (rsp_command !== want.command || rsp_pos_x !== want.pos_x ||
                   rsp_pos_y !== want.pos_y || rsp_glyph !== want.glyph ||
                   rsp_box_w !== want.box_w || rsp_box_h !== want.box_h ||
                   rsp_last !== want.last) begin
                  if (fault_count < 10) begin
                     $display("%0t: mismatch, expected cmd %0d x %0d y %0d glyph %0d",
                              $time, want.command, want.pos_x, want.pos_y, want.glyph);
                     $display("   w %0d h %0d last %0d; got cmd %0d x %0d y %0d glyph %0d",
                              want.box_w, want.box_h, want.last,
                              rsp_command, rsp_pos_x, rsp_pos_y, rsp_glyph);
                     $display("   w %0d h %0d last %0d", rsp_box_w, rsp_box_h, rsp_last);
                  end
                  fault_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            load_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            plan_commands(req_operation, req_char_code, req_set_col, req_set_row);
      end
      outstanding = draw_expect.size();
   end

endmodule

// ----- test/text_cursor_controller_top_tb.sv -----
`timescale 1ns / 100ps

module text_cursor_controller_top_tb;
   import tcc_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_operation = 1'b0;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [SET_W-1:0]      req_set_col = '0;
   logic [SET_W-1:0]      req_set_row = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_command;
   logic [POS_W-1:0]      rsp_pos_x;
   logic [POS_W-1:0]      rsp_pos_y;
   logic [CHAR_W-1:0]     rsp_glyph;
   logic [POS_W-1:0]      rsp_box_w;
   logic [POS_W-1:0]      rsp_box_h;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fault_count;
   int outstanding;

   // Idle odds per beat in percent, and a request for one long receiver hold-off
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_off_req = 1'b0;

   // Current window sizes, used to aim cursor moves
   int unsigned cfg_win_w = RST_WIN_W;
   int unsigned cfg_win_h = RST_WIN_H;

   text_cursor_controller_top dut (.*);

   text_cursor_checker checker_inst (.*);

   always #5 clock = ~clock;

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("text_cursor_controller_top_tb: errors");
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin : rsp_side
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            for (n = 0; n < HOLD_OFF_CYCLES; n++)
               @(negedge clock);
            rsp_stall = 1'b0;
            hold_off_req = 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Offer one beat and hold it until taken; valid stays high on return
   task automatic send_item(logic op, logic [CHAR_W-1:0] ch,
                            logic [SET_W-1:0] scol, logic [SET_W-1:0] srow);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_char_code = ch;
      req_set_col = scol;
      req_set_row = srow;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic print_char(logic [CHAR_W-1:0] ch);
      send_item(OP_PRINT, ch, SET_W'($urandom), SET_W'($urandom));
   endtask

   task automatic move_cursor(int unsigned col, int unsigned row);
      send_item(OP_SET, CHAR_W'($urandom), col[SET_W-1:0], row[SET_W-1:0]);
   endtask

   // Drop valid and wait until the block has nothing left in work
   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_setup(int unsigned wx, int unsigned wy, int unsigned ww,
                             int unsigned wh, int unsigned cw, int unsigned chh,
                             int unsigned tab, int unsigned md);
      drain();
      write_reg(CSR_WIN_X, wx);
      write_reg(CSR_WIN_Y, wy);
      write_reg(CSR_WIN_W, ww);
      write_reg(CSR_WIN_H, wh);
      write_reg(CSR_CELL_W, cw);
      write_reg(CSR_CELL_H, chh);
      write_reg(CSR_TAB, tab);
      write_reg(CSR_MODE, md);
      csr_valid = 1'b0;
      cfg_win_w = ww;
      cfg_win_h = wh;
   endtask

   // Mostly small windows so wrap and scroll come often
   task automatic random_setup();
      int unsigned cw;
      int unsigned chh;
      int unsigned ww;
      int unsigned wh;
      int unsigned tab;
      cw  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(4, 12);
      chh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(8, 20);
      ww  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                                        : cw * $urandom_range(2, 12) + $urandom_range(0, cw - 1);
      wh  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                                        : chh * $urandom_range(2, 8) + $urandom_range(0, chh - 1);
      if (ww > 4096) ww = 4096;
      if (wh > 4096) wh = 4096;
      case ($urandom_range(0, 9))
         0: tab = 0;
         1: tab = $urandom_range(1, 4095);
         default: tab = cw * $urandom_range(1, 6);
      endcase
      load_setup(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4095),
                 ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4095),
                 ww, wh, cw, chh, tab, $urandom_range(0, 7));
   endtask

   // Mostly text with tabs and line breaks, some cursor moves and raw bytes
   task automatic random_item();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 55)
         print_char(CHAR_W'($urandom_range(32, 126)));
      else if (k < 68)
         print_char(CHAR_TAB);
      else if (k < 76)
         print_char(($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR);
      else if (k < 84)
         move_cursor($urandom_range(0, (cfg_win_w > 4095) ? 4095 : cfg_win_w),
                     $urandom_range(0, (cfg_win_h > 4095) ? 4095 : cfg_win_h));
      else if (k < 90)
         move_cursor($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
         print_char(CHAR_W'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int ph;
      int i;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: byte extremes, tab, both line breaks, cursor at the far corner
      print_char(8'h00);
      print_char(8'hFF);
      print_char(8'h41);
      print_char(CHAR_TAB);
      print_char(CHAR_CR);
      print_char(CHAR_LF);
      move_cursor(4095, 4095);
      print_char(8'h5A);
      print_char(CHAR_TAB);
      move_cursor(0, 0);

      // Tiny window at the far corner: wrap, fill, scroll, absolute positions wrap
      load_setup(4095, 4095, 24, 32, 8, 16, 8, 7);
      print_char(8'h61);
      print_char(8'h62);
      print_char(8'h63);
      print_char(CHAR_TAB);
      print_char(CHAR_LF);
      print_char(CHAR_CR);

      // Zero tab spacing draws control codes as glyphs
      load_setup(0, 0, 640, 480, 8, 16, 0, 0);
      print_char(CHAR_TAB);
      print_char(CHAR_LF);
      print_char(CHAR_CR);

      // Zero cell size: scroll with empty span, wrap on the bare cursor
      load_setup(0, 0, 24, 32, 0, 0, 16, 3);
      move_cursor(100, 4000);
      print_char(CHAR_LF);
      move_cursor(30, 0);
      print_char(8'h78);
      print_char(CHAR_TAB);

      // Random phases; the first two sit at the extremes, the last two never idle
      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            load_setup(0, 0, 4096, 4096, 64, 64, 4095, 7);
         else if (ph == 1)
            load_setup(4095, 4095, 1, 1, 1, 1, 1, 7);
         else
            random_setup();
         if (ph >= PHASES - 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end
         // Long receiver hold-off while the sender keeps offering
         if (ph == 3)
            hold_off_req = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            random_item();
            // Sender pause until every owed command is out
            if (ph == 5 && i == PHASE_ITEMS / 2) begin
               req_valid = 1'b0;
               while (outstanding != 0)
                  @(negedge clock);
            end
         end
      end

      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("text_cursor_controller_top_tb: clean");
      else
         $display("text_cursor_controller_top_tb: errors");
      $finish;
   end

endmodule
